[src/nbody_gravity_euler_step_assert.svh]
// Assertion macros for the n-body step block.
// Depends on i_clk and i_rst_n in the including module.
`ifndef NBODY_GRAVITY_EULER_STEP_ASSERT_SVH
`define NBODY_GRAVITY_EULER_STEP_ASSERT_SVH

// hold cons in the same cycle as ante
`define NBGE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nbge assertion failed");

// hold cons in the cycle after ante
`define NBGE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nbge assertion failed");

`endif

[src/nbge_pkg.sv]
// Package for the n-body step block: payload structs, codes, states and
// saturating fixed-point helpers. No dependencies.
package nbge_pkg;

    localparam int NUM_BODIES_DEF = 8;
    localparam int FRAC_BITS_DEF  = 48;
    localparam int CFG_IDX_W      = 2;

    localparam logic [63:0] SMAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SMIN_MAG = 64'h8000_0000_0000_0000;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TIME_STEP = 2'd0;
    localparam t_cfg_idx CFG_SUN_GM    = 2'd1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef logic [2:0][63:0] t_vec;

    typedef struct packed {
        logic               operation;
        logic [2:0]         body_index;
        logic signed [63:0] pos_x;
        logic signed [63:0] pos_y;
        logic signed [63:0] pos_z;
        logic signed [63:0] vel_x;
        logic signed [63:0] vel_y;
        logic signed [63:0] vel_z;
        logic [62:0]        body_gm;
    } t_in;

    typedef struct packed {
        logic [2:0]         out_index;
        logic signed [63:0] new_x;
        logic signed [63:0] new_y;
        logic signed [63:0] new_z;
        logic               overflow;
        logic               last;
    } t_out;

    typedef struct packed {
        logic        ovf;
        logic [63:0] val;
    } t_sat;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD_I, ST_CAP_I, ST_PAIR, ST_CAP_J, ST_SQ_SET, ST_MUL,
        ST_SQRT_SET, ST_SQRT, ST_SQRT_END, ST_MD_SET, ST_DIV_SET, ST_DIV,
        ST_MD_NEXT, ST_VRD, ST_VCAP, ST_UA, ST_UB, ST_UC, ST_UD, ST_WB,
        ST_EMIT_RD, ST_EMIT_CAP
    } t_state;

    typedef enum logic {
        PH_SQ,
        PH_MD
    } t_phase;

    function automatic logic [63:0] mag64(input logic [63:0] x);
        return x[63] ? (~x) + 64'd1 : x;
    endfunction

    function automatic t_sat sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        t_sat        res;
        s       = a + b;
        res.ovf = (a[63] == b[63]) && (s[63] != a[63]);
        res.val = res.ovf ? (a[63] ? SMIN_MAG : SMAX) : s;
        return res;
    endfunction

    function automatic t_sat sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        t_sat        res;
        s       = a - b;
        res.ovf = (a[63] != b[63]) && (s[63] != a[63]);
        res.val = res.ovf ? (a[63] ? SMIN_MAG : SMAX) : s;
        return res;
    endfunction

    function automatic t_sat sat_scale(input logic [63:0] x, input logic [6:0] k);
        logic [63:0] m;
        logic [70:0] prod;
        logic [63:0] lim;
        logic [63:0] lo;
        t_sat        res;
        m       = mag64(x);
        prod    = {7'd0, m} * {64'd0, k};
        lim     = x[63] ? SMIN_MAG : SMAX;
        lo      = prod[63:0];
        res.ovf = 1'b0;
        if (prod > {7'd0, lim}) begin
            res.ovf = 1'b1;
            lo      = lim;
        end
        res.val = x[63] ? (~lo) + 64'd1 : lo;
        return res;
    endfunction

endpackage

[src/nbody_gravity_euler_step.sv]
// Operation: a load writes one body's state; a step computes, for each body term,
// one square root and nine multiply-divides, then emits the results, waiting
// while the output is held.
// Throughput: one request at a time; results leave one per body in index order.
// Reset: synchronous active low; clears control, time_step to 1, sun_gm to 0.
// Body stores have no reset and no clearing pass.
`include "nbody_gravity_euler_step_assert.svh"

module nbody_gravity_euler_step #(
    parameter int NUM_BODIES = nbge_pkg::NUM_BODIES_DEF,
    parameter int FRAC_BITS  = nbge_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  nbge_pkg::t_in      i_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output nbge_pkg::t_out     o_out,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  nbge_pkg::t_cfg_idx i_cfg_index,
    input  logic [63:0]        i_cfg_data
);
    import nbge_pkg::*;

    localparam int IW = (NUM_BODIES > 1) ? $clog2(NUM_BODIES) : 1;
    localparam int CW = $clog2(NUM_BODIES + 1);
    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    logic [CW-1:0]   r_i, n_i, r_j, n_j;
    logic [1:0]      r_k, n_k, r_s, n_s, r_pp_sh, n_pp_sh;
    logic [2:0]      r_p, n_p;
    logic [5:0]      r_cnt, n_cnt;
    t_vec            r_pi, n_pi, r_r, n_r, r_acc, n_acc, r_v, n_v;
    logic [63:0]     r_t, n_t, r_ma, n_ma, r_mb, n_mb, r_pp, n_pp;
    logic [62:0]     r_g, n_g;
    logic [127:0]    r_prod, n_prod;
    logic [65:0]     r_rem, n_rem;
    logic [63:0]     r_root, n_root, r_q, n_q;
    logic            r_f, n_f;
    logic [6:0]      r_time_step, n_time_step;
    logic [62:0]     r_sun_gm, n_sun_gm;
    logic            r_o_valid, n_o_valid;
    t_out            r_out, n_out;

    t_vec            r_pos_mem  [NUM_BODIES];
    t_vec            r_vel_mem  [NUM_BODIES];
    logic [62:0]     r_gm_mem   [NUM_BODIES];
    logic [192:0]    r_npos_mem [NUM_BODIES];
    t_vec            r_pos_rd, r_vel_rd;
    logic [62:0]     r_gm_rd;
    logic [192:0]    r_npos_rd;

    logic            pos_we, vel_we, gm_we, npos_we;
    logic [IW-1:0]   pos_wa, vel_wa, pos_ra, vel_ra, gm_ra, npos_ra;
    t_vec            pos_wd, vel_wd;
    logic [62:0]     gm_wd;
    logic [192:0]    npos_wd;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_o_valid;
    assign o_out       = r_out;

    always_comb begin
        t_sat        sa;
        logic [67:0] sq_rem;
        logic [67:0] sq_trial;
        logic [64:0] dv_t;
        logic [63:0] qq;
        logic        qovf;
        logic [31:0] a_h;
        logic [31:0] b_h;
        logic [127:0] pp_ext;

        n_state = r_state;   n_phase = r_phase;   n_i = r_i;       n_j = r_j;
        n_k = r_k;           n_s = r_s;           n_p = r_p;       n_pp_sh = r_pp_sh;
        n_cnt = r_cnt;       n_pi = r_pi;         n_r = r_r;       n_acc = r_acc;
        n_v = r_v;           n_t = r_t;           n_ma = r_ma;     n_mb = r_mb;
        n_pp = r_pp;         n_g = r_g;           n_prod = r_prod; n_rem = r_rem;
        n_root = r_root;     n_q = r_q;           n_f = r_f;
        n_time_step = r_time_step;                n_sun_gm = r_sun_gm;
        n_o_valid = r_o_valid;                    n_out = r_out;

        pos_we = 1'b0;  vel_we = 1'b0;  gm_we = 1'b0;  npos_we = 1'b0;
        pos_wa = '0;    vel_wa = '0;    pos_ra = '0;   vel_ra = '0;
        gm_ra = '0;     npos_ra = '0;
        pos_wd = '0;    vel_wd = '0;    gm_wd = '0;    npos_wd = '0;

        sa = '0;  sq_rem = '0;  sq_trial = '0;  dv_t = '0;  qq = '0;  qovf = 1'b0;
        a_h = '0; b_h = '0;     pp_ext = '0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TIME_STEP: n_time_step = i_cfg_data[6:0];
                CFG_SUN_GM:    n_sun_gm    = i_cfg_data[62:0];
                default: ;
            endcase
        end

        if (r_o_valid && i_out_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_in.operation == OP_STEP) begin
                    n_i     = '0;
                    n_state = ST_RD_I;
                end else if (i_in_valid && (32'(i_in.body_index) < NUM_BODIES)) begin
                    pos_we = 1'b1;
                    vel_we = 1'b1;
                    gm_we  = 1'b1;
                    pos_wa = IW'(i_in.body_index);
                    vel_wa = IW'(i_in.body_index);
                    pos_wd = {i_in.pos_z, i_in.pos_y, i_in.pos_x};
                    vel_wd = {i_in.vel_z, i_in.vel_y, i_in.vel_x};
                    gm_wd  = i_in.body_gm;
                end
            end
            ST_RD_I: begin
                pos_ra  = r_i[IW-1:0];
                n_state = ST_CAP_I;
            end
            ST_CAP_I: begin
                n_pi    = r_pos_rd;
                n_j     = '0;
                n_acc   = '0;
                n_f     = 1'b0;
                n_state = ST_PAIR;
            end
            ST_PAIR: begin
                n_prod = '0;
                if (r_j == r_i) begin
                    n_j = r_j + 1'b1;
                end else if (r_j == CW'(NUM_BODIES)) begin
                    n_r     = r_pi;
                    n_g     = r_sun_gm;
                    n_k     = '0;
                    n_state = ST_SQ_SET;
                end else begin
                    pos_ra  = r_j[IW-1:0];
                    gm_ra   = r_j[IW-1:0];
                    n_state = ST_CAP_J;
                end
            end
            ST_CAP_J: begin
                for (int c = 0; c < 3; c++) begin
                    sa     = sat_sub(r_pi[c], r_pos_rd[c]);
                    n_r[c] = sa.val;
                    if (sa.ovf) n_f = 1'b1;
                end
                n_g     = r_gm_rd;
                n_k     = '0;
                n_state = ST_SQ_SET;
            end
            ST_SQ_SET: begin
                n_ma    = mag64(r_r[r_k]);
                n_mb    = mag64(r_r[r_k]);
                n_p     = '0;
                n_phase = PH_SQ;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                if (r_p != 3'd4) begin
                    a_h     = r_p[1] ? r_ma[63:32] : r_ma[31:0];
                    b_h     = r_p[0] ? r_mb[63:32] : r_mb[31:0];
                    n_pp    = {32'd0, a_h} * {32'd0, b_h};
                    n_pp_sh = {1'b0, r_p[1]} + {1'b0, r_p[0]};
                end
                if (r_p != 3'd0) begin
                    case (r_pp_sh)
                        2'd0:    pp_ext = {64'd0, r_pp};
                        2'd1:    pp_ext = {32'd0, r_pp, 32'd0};
                        default: pp_ext = {r_pp, 64'd0};
                    endcase
                    n_prod = r_prod + pp_ext;
                end
                if (r_p == 3'd4) begin
                    if (r_phase == PH_SQ) begin
                        if (r_k == 2'd2) begin
                            n_state = ST_SQRT_SET;
                        end else begin
                            n_k     = r_k + 2'd1;
                            n_state = ST_SQ_SET;
                        end
                    end else begin
                        n_state = ST_DIV_SET;
                    end
                end else begin
                    n_p = r_p + 3'd1;
                end
            end
            ST_SQRT_SET: begin
                n_rem   = '0;
                n_root  = '0;
                n_cnt   = 6'd63;
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                sq_rem   = {r_rem, r_prod[127:126]};
                sq_trial = {2'b00, r_root, 2'b01};
                if (sq_rem >= sq_trial) begin
                    n_rem  = 66'(sq_rem - sq_trial);
                    n_root = {r_root[62:0], 1'b1};
                end else begin
                    n_rem  = sq_rem[65:0];
                    n_root = {r_root[62:0], 1'b0};
                end
                n_prod = r_prod << 2;
                if (r_cnt == 6'd0) begin
                    n_state = ST_SQRT_END;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            ST_SQRT_END: begin
                if (r_root == 64'd0) begin
                    n_f = 1'b1;
                    if (r_j == CW'(NUM_BODIES)) begin
                        n_state = ST_VRD;
                    end else begin
                        n_j     = r_j + 1'b1;
                        n_state = ST_PAIR;
                    end
                end else begin
                    n_k     = '0;
                    n_s     = '0;
                    n_state = ST_MD_SET;
                end
            end
            ST_MD_SET: begin
                n_ma    = (r_s == 2'd0) ? {1'b0, r_g} : r_q;
                n_mb    = (r_s == 2'd0) ? mag64(r_r[r_k]) : ONE;
                n_prod  = '0;
                n_p     = '0;
                n_phase = PH_MD;
                n_state = ST_MUL;
            end
            ST_DIV_SET: begin
                if (r_prod[127:64] >= r_root) begin
                    n_q     = SMAX;
                    n_f     = 1'b1;
                    n_state = ST_MD_NEXT;
                end else begin
                    n_rem   = {2'b00, r_prod[127:64]};
                    n_q     = '0;
                    n_cnt   = 6'd63;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                dv_t = {r_rem[63:0], r_prod[63]};
                if (dv_t >= {1'b0, r_root}) begin
                    n_rem = {2'b00, 64'(dv_t - {1'b0, r_root})};
                    n_q   = {r_q[62:0], 1'b1};
                end else begin
                    n_rem = {2'b00, dv_t[63:0]};
                    n_q   = {r_q[62:0], 1'b0};
                end
                n_prod = r_prod << 1;
                if (r_cnt == 6'd0) begin
                    n_state = ST_MD_NEXT;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            ST_MD_NEXT: begin
                qovf = r_q[63];
                qq   = qovf ? SMAX : r_q;
                if (qovf) n_f = 1'b1;
                if (r_s != 2'd2) begin
                    n_q     = qq;
                    n_s     = r_s + 2'd1;
                    n_state = ST_MD_SET;
                end else begin
                    sa         = sat_add(r_acc[r_k], r_r[r_k][63] ? qq : (~qq) + 64'd1);
                    n_acc[r_k] = sa.val;
                    if (sa.ovf) n_f = 1'b1;
                    if (r_k == 2'd2) begin
                        if (r_j == CW'(NUM_BODIES)) begin
                            n_state = ST_VRD;
                        end else begin
                            n_j     = r_j + 1'b1;
                            n_state = ST_PAIR;
                        end
                    end else begin
                        n_k     = r_k + 2'd1;
                        n_s     = '0;
                        n_state = ST_MD_SET;
                    end
                end
            end
            ST_VRD: begin
                vel_ra  = r_i[IW-1:0];
                n_state = ST_VCAP;
            end
            ST_VCAP: begin
                n_v     = r_vel_rd;
                n_k     = '0;
                n_state = ST_UA;
            end
            ST_UA: begin
                sa  = sat_scale(r_acc[r_k], r_time_step);
                n_t = sa.val;
                if (sa.ovf) n_f = 1'b1;
                n_state = ST_UB;
            end
            ST_UB: begin
                sa       = sat_add(r_v[r_k], r_t);
                n_v[r_k] = sa.val;
                if (sa.ovf) n_f = 1'b1;
                n_state = ST_UC;
            end
            ST_UC: begin
                sa  = sat_scale(r_v[r_k], r_time_step);
                n_t = sa.val;
                if (sa.ovf) n_f = 1'b1;
                n_state = ST_UD;
            end
            ST_UD: begin
                sa       = sat_add(r_pi[r_k], r_t);
                n_r[r_k] = sa.val;
                if (sa.ovf) n_f = 1'b1;
                if (r_k == 2'd2) begin
                    n_state = ST_WB;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = ST_UA;
                end
            end
            ST_WB: begin
                vel_we  = 1'b1;
                vel_wa  = r_i[IW-1:0];
                vel_wd  = r_v;
                npos_we = 1'b1;
                npos_wd = {r_f, r_r};
                if (r_i == CW'(NUM_BODIES - 1)) begin
                    n_i     = '0;
                    n_state = ST_EMIT_RD;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_RD_I;
                end
            end
            ST_EMIT_RD: begin
                if (!r_o_valid || i_out_ready) begin
                    npos_ra = r_i[IW-1:0];
                    n_state = ST_EMIT_CAP;
                end
            end
            ST_EMIT_CAP: begin
                n_out.out_index = 3'(r_i);
                n_out.new_x     = r_npos_rd[63:0];
                n_out.new_y     = r_npos_rd[127:64];
                n_out.new_z     = r_npos_rd[191:128];
                n_out.overflow  = r_npos_rd[192];
                n_out.last      = (r_i == CW'(NUM_BODIES - 1));
                n_o_valid       = 1'b1;
                pos_we          = 1'b1;
                pos_wa          = r_i[IW-1:0];
                pos_wd          = r_npos_rd[191:0];
                if (r_i == CW'(NUM_BODIES - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_EMIT_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_o_valid   <= 1'b0;
            r_time_step <= 7'd1;
            r_sun_gm    <= '0;
        end else begin
            r_state     <= n_state;
            r_o_valid   <= n_o_valid;
            r_time_step <= n_time_step;
            r_sun_gm    <= n_sun_gm;
        end
    end

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;  r_i <= n_i;       r_j <= n_j;       r_k <= n_k;
        r_s <= n_s;          r_p <= n_p;       r_pp_sh <= n_pp_sh;
        r_cnt <= n_cnt;      r_pi <= n_pi;     r_r <= n_r;       r_acc <= n_acc;
        r_v <= n_v;          r_t <= n_t;       r_ma <= n_ma;     r_mb <= n_mb;
        r_pp <= n_pp;        r_g <= n_g;       r_prod <= n_prod; r_rem <= n_rem;
        r_root <= n_root;    r_q <= n_q;       r_f <= n_f;       r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) r_pos_mem[pos_wa] <= pos_wd;
        r_pos_rd <= r_pos_mem[pos_ra];
    end

    always_ff @(posedge i_clk) begin
        if (vel_we) r_vel_mem[vel_wa] <= vel_wd;
        r_vel_rd <= r_vel_mem[vel_ra];
    end

    always_ff @(posedge i_clk) begin
        if (gm_we) r_gm_mem[pos_wa] <= gm_wd;
        r_gm_rd <= r_gm_mem[gm_ra];
    end

    always_ff @(posedge i_clk) begin
        if (npos_we) r_npos_mem[vel_wa] <= npos_wd;
        r_npos_rd <= r_npos_mem[npos_ra];
    end

    `NBGE_ASSERT_SAME(a_emit_slot_free, r_state == ST_EMIT_CAP, !r_o_valid)
    `NBGE_ASSERT_NEXT(a_step_starts, i_in_valid && o_in_ready && i_in.operation == OP_STEP, r_state == ST_RD_I)
    `NBGE_ASSERT_SAME(a_div_rem_below, r_state == ST_DIV, r_rem[63:0] < r_root)

endmodule
